// File: hdl/nia_pkg.sv
`timescale 1ns / 1ps
// nia_pkg: shared types and constants of the nullable integer arithmetic unit.
// No dependencies.
package nia_pkg;

	localparam int VALUE_W = 64;
	localparam int OP_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// control that rides along with each beat through the cell row
	typedef struct packed {
		logic vld;
		op_t  op;
		logic present;
		logic neg;
	} nia_ctl_t;

endpackage

// File: hdl/nia_if.sv
`timescale 1ns / 1ps
// nia_if: valid/ready channel interfaces for operands, results and configuration.
// Depends on nia_pkg.
interface nia_opnd_if import nia_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] left_value;
	logic               left_present;
	logic [VALUE_W-1:0] right_value;
	logic               right_present;

	modport source (output valid, left_value, left_present, right_value, right_present,
		input ready);
	modport sink (input valid, left_value, left_present, right_value, right_present,
		output ready);
endinterface

interface nia_res_if import nia_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] result_value;
	logic               result_present;

	modport source (output valid, result_value, result_present, input ready);
	modport sink (input valid, result_value, result_present, output ready);
endinterface

interface nia_cfg_if import nia_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] operation;

	modport source (output valid, operation, input ready);
	modport sink (input valid, operation, output ready);
endinterface

// File: hdl/nia_front.sv
`timescale 1ns / 1ps
// nia_front: entry stage; null/zero-divisor check, add/sub, operand setup for the cell row.
// Depends on nia_pkg.
module nia_front import nia_pkg::*; #(
	parameter int W = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  op_t           op,
	input  logic [W-1:0]  a,
	input  logic          a_present,
	input  logic [W-1:0]  b,
	input  logic          b_present,
	output nia_ctl_t      ctl_s1,
	output logic [W-1:0]  acc_s1,
	output logic [W-1:0]  x_s1,
	output logic [W-1:0]  y_s1
);

	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W-1:0] acc_d;
	logic [W-1:0] x_d;
	logic [W-1:0] y_d;
	nia_ctl_t     ctl_d;

	always_comb begin
		a_mag = a[W-1] ? (~a + 1'b1) : a;
		b_mag = b[W-1] ? (~b + 1'b1) : b;
		acc_d = '0;
		x_d   = '0;
		y_d   = '0;
		unique case (op)
			OP_ADD: begin
				acc_d = a + b;
			end
			OP_SUB: begin
				acc_d = a - b;
			end
			OP_MUL: begin
				x_d = a;
				y_d = b;
			end
			OP_DIV: begin
				x_d = a_mag;
				y_d = b_mag;
			end
		endcase
		ctl_d.vld     = in_vld;
		ctl_d.op      = op;
		ctl_d.present = a_present & b_present & ~((op == OP_DIV) && (b == '0));
		ctl_d.neg     = a[W-1] ^ b[W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s1 <= acc_d;
			x_s1   <= x_d;
			y_s1   <= y_d;
		end
	end

endmodule

// File: hdl/nia_cell.sv
`timescale 1ns / 1ps
// nia_cell: one step of the row; a shift-add step for multiply,
// a restoring quotient-bit step for divide, pass-through otherwise. Depends on nia_pkg.
module nia_cell import nia_pkg::*; #(
	parameter int W = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  nia_ctl_t      ctl_i,
	input  logic [W-1:0]  acc_i,
	input  logic [W-1:0]  x_i,
	input  logic [W-1:0]  y_i,
	output nia_ctl_t      ctl_q,
	output logic [W-1:0]  acc_q,
	output logic [W-1:0]  x_q,
	output logic [W-1:0]  y_q
);

	logic [W-1:0] rem_sh;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] acc_d;
	logic [W-1:0] x_d;
	logic [W-1:0] y_d;

	always_comb begin
		// remainder stays below the divisor, so its top bit is always clear
		rem_sh = {acc_i[W-2:0], x_i[W-1]};
		diff   = {1'b0, rem_sh} - {1'b0, y_i};
		ge     = ~diff[W];
		unique case (ctl_i.op)
			OP_ADD, OP_SUB: begin
				acc_d = acc_i;
				x_d   = x_i;
				y_d   = y_i;
			end
			OP_MUL: begin
				acc_d = y_i[0] ? (acc_i + x_i) : acc_i;
				x_d   = {x_i[W-2:0], 1'b0};
				y_d   = {1'b0, y_i[W-1:1]};
			end
			OP_DIV: begin
				acc_d = ge ? diff[W-1:0] : rem_sh;
				x_d   = {x_i[W-2:0], ge};
				y_d   = y_i;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
		end
	end

endmodule

// File: hdl/nia_out.sv
`timescale 1ns / 1ps
// nia_out: final sign fix-up, null masking and output register with skid stage.
// Depends on nia_pkg.
module nia_out import nia_pkg::*; #(
	parameter int W = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nia_ctl_t           ctl_i,
	input  logic [W-1:0]       acc_i,
	input  logic [W-1:0]       x_i,
	output logic               adv,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [VALUE_W-1:0] res_value,
	output logic               res_present
);

	logic [W-1:0]       quo;
	logic [W-1:0]       r;
	logic [W-1:0]       val_w;
	logic [VALUE_W-1:0] pipe_value;
	logic               take;
	logic               load_main;

	logic               main_v_q;
	logic [VALUE_W-1:0] main_value_q;
	logic               main_present_q;
	logic               skid_v_q;
	logic [VALUE_W-1:0] skid_value_q;
	logic               skid_present_q;

	always_comb begin
		quo = ctl_i.neg ? (~x_i + 1'b1) : x_i;
		unique case (ctl_i.op)
			OP_ADD, OP_SUB, OP_MUL: r = acc_i;
			OP_DIV:                 r = quo;
		endcase
		val_w      = ctl_i.present ? r : '0;
		pipe_value = VALUE_W'($signed(val_w));
	end

	assign adv       = ~skid_v_q;
	assign take      = ctl_i.vld & adv;
	assign load_main = res_ready | ~main_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_main) begin
			main_v_q <= skid_v_q | take;
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			if (skid_v_q) begin
				main_value_q   <= skid_value_q;
				main_present_q <= skid_present_q;
			end else begin
				main_value_q   <= pipe_value;
				main_present_q <= ctl_i.present;
			end
		end else if (take) begin
			skid_value_q   <= pipe_value;
			skid_present_q <= ctl_i.present;
		end
	end

	assign res_valid   = main_v_q;
	assign res_value   = main_value_q;
	assign res_present = main_present_q;

endmodule

// File: hdl/nullable_int64_arith_unit.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle for every operation while the skid stage is empty;
//   the row of DATA_WIDTH cells retires one multiplier bit or one quotient bit per cell,
//   so it holds that many beats.
// Reset (arst_n low, asynchronous): all valid bits cleared, operation returns to add.
// Backpressure: output register plus skid stage; operand ready is a flop output.
module nullable_int64_arith_unit import nia_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	nia_cfg_if.sink    cfg,
	nia_opnd_if.sink   opnd,
	nia_res_if.source  res
);

	// operation register; the user must write it only while idle, the block does not enforce this
	op_t op_q;

	// advance of the whole row; low only while the skid stage is occupied
	logic adv;

	// cell row taps: index 0 is the entry stage, index DATA_WIDTH the last cell
	nia_ctl_t              ctl_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] acc_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] x_c   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] y_c   [0:DATA_WIDTH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
		end else if (cfg.valid) begin
			op_q <= op_t'(cfg.operation);
		end
	end

	assign opnd.ready = adv;

	// entry: only the low DATA_WIDTH bits of each operand count
	nia_front #(.W(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_vld    (opnd.valid),
		.op        (op_q),
		.a         (opnd.left_value[DATA_WIDTH-1:0]),
		.a_present (opnd.left_present),
		.b         (opnd.right_value[DATA_WIDTH-1:0]),
		.b_present (opnd.right_present),
		.ctl_s1    (ctl_c[0]),
		.acc_s1    (acc_c[0]),
		.x_s1      (x_c[0]),
		.y_s1      (y_c[0])
	);

	// one cell per operand bit: multiply shifts x left and y right,
	// divide shifts the dividend out of x and the quotient bits into it
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		nia_cell #(.W(DATA_WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctl_i  (ctl_c[i]),
			.acc_i  (acc_c[i]),
			.x_i    (x_c[i]),
			.y_i    (y_c[i]),
			.ctl_q  (ctl_c[i+1]),
			.acc_q  (acc_c[i+1]),
			.x_q    (x_c[i+1]),
			.y_q    (y_c[i+1])
		);
	end

	// sign of the quotient, null masking, sign extension to 64 bits, output skid
	nia_out #(.W(DATA_WIDTH)) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_i       (ctl_c[DATA_WIDTH]),
		.acc_i       (acc_c[DATA_WIDTH]),
		.x_i         (x_c[DATA_WIDTH]),
		.adv         (adv),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.res_value   (res.result_value),
		.res_present (res.result_present)
	);

	// y of the last cell is not needed past the row
	logic unused_y;
	assign unused_y = ^y_c[DATA_WIDTH];

endmodule

// File: hdl/nia_chk.sv
`timescale 1ns / 1ps
// nia_chk: port-level assertions for nullable_int64_arith_unit, plus the bind.
// Depends on nia_pkg.
module nia_chk import nia_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               opnd_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [VALUE_W-1:0] res_value,
	input logic               res_present
);

	// a null result carries zero
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_present |-> res_value == '0)
		else $error("null result with nonzero value");

	// result is a sign extension of a DATA_WIDTH-bit value
	a_sign_ext: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_value[VALUE_W-1:DATA_WIDTH-1] == '0) ||
			(res_value[VALUE_W-1:DATA_WIDTH-1] == '1))
		else $error("result not sign extended");

	// skid is empty in the cycle after the sink is ready
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |=> opnd_ready)
		else $error("operand ready stuck low after result ready");

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_present))
		else $error("stalled result beat changed");

endmodule

bind nullable_int64_arith_unit nia_chk #(.DATA_WIDTH(DATA_WIDTH)) u_nia_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.opnd_ready  (opnd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_value   (res.result_value),
	.res_present (res.result_present)
);

// File: tb/sv/nia_result_checker.sv
`timescale 1ns / 1ps
// nia_result_checker: passive monitor that predicts each result beat of the
// nullable integer arithmetic unit and compares it. Depends on nia_pkg, nia_if.
module nia_result_checker import nia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	nia_cfg_if          cfg,
	nia_opnd_if         opnd,
	nia_res_if          res,
	output int unsigned results_seen,
	output int unsigned outstanding,
	output int unsigned mismatches
);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               present;
	} arith_result_t;

	op_t           cur_op;
	arith_result_t pending_results[$];
	arith_result_t oldest;

	// null in -> null out; divide by zero -> null; everything else wraps at 64 bits
	function automatic arith_result_t apply_operation(op_t op,
			logic [VALUE_W-1:0] a, logic a_ok, logic [VALUE_W-1:0] b, logic b_ok);
		arith_result_t      r;
		logic [VALUE_W-1:0] mag_a;
		logic [VALUE_W-1:0] mag_b;
		logic [VALUE_W-1:0] quot;
		r.value   = '0;
		r.present = a_ok && b_ok;
		if (r.present) begin
			case (op)
				OP_ADD: r.value = a + b;
				OP_SUB: r.value = a - b;
				OP_MUL: r.value = a * b;
				default: begin
					if (b == '0) begin
						r.present = 1'b0;
					end else begin
						// unsigned magnitudes; the minimum value maps onto itself as 2^63
						mag_a = a[VALUE_W-1] ? -a : a;
						mag_b = b[VALUE_W-1] ? -b : b;
						quot  = mag_a / mag_b;
						r.value = (a[VALUE_W-1] ^ b[VALUE_W-1]) ? -quot : quot;
					end
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_op <= OP_ADD;
			pending_results.delete();
			results_seen <= 0;
			outstanding  <= 0;
			mismatches   = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				cur_op <= op_t'(cfg.operation);
			// retire before enqueue so a stray result never matches a fresh beat
			if (res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected: value %h present %b",
						res.result_value, res.result_present);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					if (res.result_present !== oldest.present) begin
						$error("result_present mismatch: expected %b, got %b",
							oldest.present, res.result_present);
						mismatches++;
					end
					if (res.result_value !== oldest.value) begin
						$error("result_value mismatch: expected %h, got %h",
							oldest.value, res.result_value);
						mismatches++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (opnd.valid && opnd.ready)
				pending_results.insert(pending_results.size(),
					apply_operation(cur_op, opnd.left_value, opnd.left_present,
						opnd.right_value, opnd.right_present));
			outstanding <= pending_results.size();
		end
	end

endmodule

// File: tb/sv/nullable_int64_arith_unit_test.sv
`timescale 1ns / 1ps
// nullable_int64_arith_unit_test: stimulus and verdict for the nullable integer
// arithmetic unit. Depends on nia_pkg, nia_if, nia_result_checker and the RTL.
module nullable_int64_arith_unit_test;
	import nia_pkg::*;

	localparam int          LATENCY     = 65;
	localparam int          SEGMENT_LEN = 150;     // random beats per operation setting
	localparam int unsigned CYCLE_LIMIT = 200000;

	localparam logic [VALUE_W-1:0] MIN_VAL = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] MAX_VAL = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] ONES    = '1;

	logic clk;
	logic arst_n;

	nia_cfg_if  cfg_ch();
	nia_opnd_if opnd_ch();
	nia_res_if  res_ch();

	int unsigned results_seen;
	int unsigned outstanding;
	int unsigned mismatches;

	// stimulus bookkeeping
	int unsigned beats_sent;
	int unsigned null_beats;
	int unsigned zero_divides;
	int unsigned cycles;
	int          send_gap_pct;
	int          recv_stall_pct;
	op_t         cur_op;

	nullable_int64_arith_unit #(.DATA_WIDTH(VALUE_W)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.opnd   (opnd_ch),
		.res    (res_ch)
	);

	nia_result_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_ch),
		.opnd         (opnd_ch),
		.res          (res_ch),
		.results_seen (results_seen),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: any hang lands here
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d results seen",
				cycles, results_seen, beats_sent);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side backpressure; a fresh draw every cycle spreads stalls over
	// every stage of the row
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// operand mix: full range, small values around zero, the extremes, and
	// shifted values so that divides give quotients of every size
	function automatic logic [VALUE_W-1:0] pick_operand();
		logic [VALUE_W-1:0] v;
		int                 sel;
		sel = $urandom_range(9);
		v   = {$urandom, $urandom};
		case (sel)
			4, 5: v = VALUE_W'($urandom_range(32)) - VALUE_W'(16);
			6: begin
				case ($urandom_range(4))
					0: v = MIN_VAL;
					1: v = MAX_VAL;
					2: v = '0;
					3: v = ONES;
					default: v = VALUE_W'(1);
				endcase
			end
			7, 8: v = $signed(v) >>> $urandom_range(VALUE_W-1);
			9: v = v >> $urandom_range(VALUE_W-1);
			default: ;
		endcase
		return v;
	endfunction

	// one operand beat; valid stays high into the next beat unless a gap is drawn
	task automatic push_operands(input logic [VALUE_W-1:0] l, input logic lp,
			input logic [VALUE_W-1:0] r, input logic rp);
		while ($urandom_range(99) < send_gap_pct) begin
			opnd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		opnd_ch.valid         <= 1'b1;
		opnd_ch.left_value    <= l;
		opnd_ch.left_present  <= lp;
		opnd_ch.right_value   <= r;
		opnd_ch.right_present <= rp;
		do @(posedge clk); while (!opnd_ch.ready);
		beats_sent++;
		if (!(lp && rp))
			null_beats++;
		else if (cur_op == OP_DIV && r == '0)
			zero_divides++;
	endtask

	// wait until every beat sent has come back; the checker counts are registered,
	// so the first sample is taken in the cycle after the last operand beat
	task automatic drain();
		opnd_ch.valid <= 1'b0;
		do @(posedge clk); while (results_seen != beats_sent);
	endtask

	// only called with the row empty
	task automatic write_operation(input op_t op);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.operation <= op;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_op = op;
	endtask

	initial begin
		op_t ops[4];
		int  failures;

		// every input known from time zero
		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.operation      = OP_ADD;
		opnd_ch.valid         = 1'b0;
		opnd_ch.left_value    = '0;
		opnd_ch.left_present  = 1'b0;
		opnd_ch.right_value   = '0;
		opnd_ch.right_present = 1'b0;
		send_gap_pct          = 0;
		recv_stall_pct        = 0;
		cur_op                = OP_ADD;
		beats_sent            = 0;
		null_beats            = 0;
		zero_divides          = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: same six operand pairs under every operation
		ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
		foreach (ops[k]) begin
			write_operation(ops[k]);
			push_operands(MAX_VAL, 1'b1, MAX_VAL, 1'b1);           // overflow
			push_operands(MIN_VAL, 1'b1, ONES, 1'b1);              // min by minus one
			push_operands(-VALUE_W'(7), 1'b1, VALUE_W'(2), 1'b1);  // truncation toward zero
			push_operands(VALUE_W'(5), 1'b1, '0, 1'b1);            // zero divisor
			push_operands(VALUE_W'(3), 1'b0, VALUE_W'(4), 1'b1);   // left null
			push_operands(ONES, 1'b1, ONES, 1'b0);                 // right null, junk value
			drain();
		end

		// random: three idling modes, each running all four operations
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_gap_pct = 9;  recv_stall_pct = 69; end
				1: begin send_gap_pct = 69; recv_stall_pct = 9;  end
				default: begin send_gap_pct = 0; recv_stall_pct = 0; end
			endcase
			ops = '{OP_DIV, OP_ADD, OP_MUL, OP_SUB};
			for (int k = 0; k < 4; k++) begin
				write_operation(ops[(k + mode) % 4]);
				repeat (SEGMENT_LEN)
					push_operands(pick_operand(), ($urandom_range(9) != 0),
						pick_operand(), ($urandom_range(9) != 0));
				drain();
			end
		end

		// quiet tail: anything extra coming out of the row gets flagged
		repeat (LATENCY + 5) @(posedge clk);

		failures = mismatches;
		if (outstanding != 0) begin
			$error("%0d expected results never arrived", outstanding);
			failures++;
		end

		$display("Covered %0d operand beats over add, subtract, multiply and divide under",
			beats_sent);
		$display("three idling modes; %0d had a null operand, %0d divided by zero.",
			null_beats, zero_divides);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
